// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/slbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slbm_pkg
// shared types and constants of the label to boundary map core
// ----------------------------------------------------------------------------
package slbm_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int MAX_FRAME  = 4096;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam cfg_t RST_FRAME_WIDTH  = 13'd640;
    localparam cfg_t RST_FRAME_HEIGHT = 13'd480;

    // result slots of one pixel, in emission order
    localparam int SLOT_UP_LEFT = 0;
    localparam int SLOT_UP      = 1;
    localparam int SLOT_LEFT    = 2;
    localparam int SLOT_HERE    = 3;
    localparam int NUM_SLOTS    = 4;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    localparam int OUT_DATA_BITS = 32;

endpackage

// ===== hw/rtl/slbm_line_buf.sv =====
// ----------------------------------------------------------------------------
// slbm_line_buf
// single port line store, read-before-write, registered read data
// ----------------------------------------------------------------------------
module slbm_line_buf #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/segment_label_to_boundary_map_core.sv =====
// ----------------------------------------------------------------------------
// segment_label_to_boundary_map_core
// segment labels in raster order in, boundary map words tagged with row and
// column out
// ----------------------------------------------------------------------------
// One label word is taken per clock while the pixel before it has no result
// words left or sends its last one. Each pixel yields zero to four result words
// (one for an interior pixel, two in the last column and row, four for the last
// pixel), and the single output register sends one per clock while the sink is
// ready. Results pass through the emit stage and then the output register. The
// previous row sits in an internal line store that is read and rewritten at the
// same column as each pixel arrives; its contents are not cleared at reset, so
// the first frame after reset starts cleanly only because row zero writes every
// column before row one reads it. Writing frame_width or frame_height restarts
// the frame at pixel (0,0); write them only while no words are in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_label_to_boundary_map_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [slbm_pkg::CFG_BITS-1:0]       cfg_wdata,
    // label stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((LABEL_BITS+7)/8)*8-1:0]     s_tdata,   // label
    // boundary stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slbm_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // out_row, out_col, edge_res
    output logic                                m_tlast
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WCAP   = (MAX_WIDTH < slbm_pkg::MAX_FRAME) ? MAX_WIDTH
                                                              : slbm_pkg::MAX_FRAME;
    localparam int CB     = slbm_pkg::COORD_BITS;
    localparam int PAD_W  = slbm_pkg::OUT_DATA_BITS - 2*CB - 1;

    typedef logic [LABEL_BITS-1:0] label_t;

    // config registers
    slbm_pkg::cfg_t   width_reg;
    slbm_pkg::cfg_t   height_reg;
    slbm_pkg::coord_t last_col;
    slbm_pkg::coord_t last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= slbm_pkg::RST_FRAME_WIDTH;
            height_reg <= slbm_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                slbm_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                slbm_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slbm_pkg::cfg_t w_eff;
        slbm_pkg::cfg_t h_eff;
        w_eff = width_reg;
        if (w_eff == '0)
            w_eff = slbm_pkg::cfg_t'(1);
        else if (w_eff > slbm_pkg::cfg_t'(WCAP))
            w_eff = slbm_pkg::cfg_t'(WCAP);
        h_eff = height_reg;
        if (h_eff == '0)
            h_eff = slbm_pkg::cfg_t'(1);
        else if (h_eff > slbm_pkg::cfg_t'(slbm_pkg::MAX_FRAME))
            h_eff = slbm_pkg::cfg_t'(slbm_pkg::MAX_FRAME);
        last_col = CB'(w_eff - slbm_pkg::cfg_t'(1));
        last_row = CB'(h_eff - slbm_pkg::cfg_t'(1));
    end

    // raster position of the next input pixel
    slbm_pkg::coord_t row_reg, row_next;
    slbm_pkg::coord_t col_reg, col_next;

    logic   accept;
    label_t in_label;

    assign in_label = s_tdata[LABEL_BITS-1:0];
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + CB'(1);
            end
            else
            begin
                col_next = col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line store: read the label above, write the current one back
    label_t up_label;

    slbm_line_buf #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LABEL_BITS)
    ) u_line_buf (
        .clk   (clk),
        .en    (accept),
        .addr  (ADDR_W'(col_reg)),
        .wdata (in_label),
        .rdata (up_label)
    );

    // which results the pixel produces
    slbm_pkg::slot_mask_t new_mask;

    always_comb
    begin
        new_mask = '0;
        new_mask[slbm_pkg::SLOT_UP_LEFT] = (row_reg != '0) && (col_reg != '0);
        new_mask[slbm_pkg::SLOT_UP]      = (row_reg != '0) && (col_reg == last_col);
        new_mask[slbm_pkg::SLOT_LEFT]    = (row_reg == last_row) && (col_reg != '0);
        new_mask[slbm_pkg::SLOT_HERE]    = (row_reg == last_row) && (col_reg == last_col);
    end

    // emit stage
    logic                 s1_valid_reg;
    slbm_pkg::slot_mask_t pend_reg;
    slbm_pkg::slot_mask_t pend_clr;
    slbm_pkg::slot_mask_t sel_hot;
    label_t               s1_label_reg;
    slbm_pkg::coord_t     s1_row_reg;
    slbm_pkg::coord_t     s1_col_reg;
    label_t               left_reg;
    label_t               upleft_reg;

    logic                 emit_go;
    logic                 s1_done;
    logic [slbm_pkg::NUM_SLOTS-1:0] slot_edge;

    always_comb
    begin
        sel_hot = pend_reg & (~pend_reg + slbm_pkg::slot_mask_t'(1));
        pend_clr = pend_reg & ~sel_hot;
    end

    assign emit_go  = s1_valid_reg && (pend_reg != '0) && (!m_tvalid || m_tready);
    assign s1_done  = !s1_valid_reg || (pend_reg == '0) || (emit_go && (pend_clr == '0));
    assign s_tready = s1_done;

    always_comb
    begin
        slot_edge = '0;
        slot_edge[slbm_pkg::SLOT_UP_LEFT] = (upleft_reg != up_label) ||
                                            (left_reg != s1_label_reg) ||
                                            (upleft_reg != left_reg) ||
                                            (up_label != s1_label_reg);
        slot_edge[slbm_pkg::SLOT_UP]      = (up_label != s1_label_reg);
        slot_edge[slbm_pkg::SLOT_LEFT]    = (left_reg != s1_label_reg);
        slot_edge[slbm_pkg::SLOT_HERE]    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            left_reg     <= '0;
            upleft_reg   <= '0;
        end
        else
        begin
            if (s1_valid_reg && s1_done)
            begin
                left_reg   <= s1_label_reg;
                upleft_reg <= up_label;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                pend_reg     <= new_mask;
            end
            else
            begin
                if (s1_done)
                    s1_valid_reg <= 1'b0;
                if (emit_go)
                    pend_reg <= pend_clr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_label_reg <= in_label;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
        end
    end

    // output register
    logic             out_valid_reg;
    slbm_pkg::coord_t out_row_reg;
    slbm_pkg::coord_t out_col_reg;
    logic             out_edge_reg;
    logic             out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_go)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_row_reg  <= (sel_hot[slbm_pkg::SLOT_UP_LEFT] || sel_hot[slbm_pkg::SLOT_UP])
                            ? s1_row_reg - CB'(1) : s1_row_reg;
            out_col_reg  <= (sel_hot[slbm_pkg::SLOT_UP_LEFT] || sel_hot[slbm_pkg::SLOT_LEFT])
                            ? s1_col_reg - CB'(1) : s1_col_reg;
            out_edge_reg <= |(sel_hot & slot_edge);
            out_last_reg <= (pend_clr == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_edge_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_ALWAYS(a_col_in_frame, col_reg <= last_col)
    `ASSERT_ALWAYS(a_row_in_frame, row_reg <= last_row)
    `ASSERT_IMPLIES(a_pend_needs_item, pend_reg != '0, s1_valid_reg)
    `ASSERT_IMPLIES(a_corner_is_clear, m_tvalid && out_row_reg == last_row && out_col_reg == last_col, !out_edge_reg)

endmodule

// ===== test/boundary_map_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_map_monitor
// watches the config port and both streams of the label to boundary map core,
// predicts every boundary word from the accepted labels and checks each
// delivered word, in order, against the oldest prediction
// ----------------------------------------------------------------------------
module boundary_map_monitor #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  slbm_pkg::cfg_t                       cfg_wdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [((LABEL_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [slbm_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                 m_tlast,
    output int                                   mismatches,
    output int                                   pending_words,
    output int                                   words_seen
);

    typedef struct packed {
        slbm_pkg::coord_t row;
        slbm_pkg::coord_t col;
        logic             on_edge;
        logic             last;
    } bmap_word_t;

    localparam int WIDTH_CAP = (MAX_WIDTH < slbm_pkg::MAX_FRAME) ? MAX_WIDTH
                                                                 : slbm_pkg::MAX_FRAME;
    localparam int CB        = slbm_pkg::COORD_BITS;
    localparam int DW        = slbm_pkg::OUT_DATA_BITS;

    logic [LABEL_BITS-1:0] prev_row [0:MAX_WIDTH-1];
    logic [LABEL_BITS-1:0] west_label;
    logic [LABEL_BITS-1:0] north_west_label;
    int                    row_at;
    int                    col_at;
    slbm_pkg::cfg_t        width_cfg;
    slbm_pkg::cfg_t        height_cfg;
    bmap_word_t            boundary_q [$];

    function automatic int frame_dim(slbm_pkg::cfg_t v, int cap);
        if (v == 0)
            return 1;
        if (int'(v) > cap)
            return cap;
        return int'(v);
    endfunction

    function automatic bmap_word_t make_word(int r, int c, logic on_edge);
        bmap_word_t wd;
        wd.row     = slbm_pkg::coord_t'(r);
        wd.col     = slbm_pkg::coord_t'(c);
        wd.on_edge = on_edge;
        wd.last    = 1'b0;
        return wd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        int                    w;
        int                    h;
        int                    r;
        int                    c;
        int                    n;
        int                    k;
        logic [LABEL_BITS-1:0] lab;
        logic [LABEL_BITS-1:0] up;
        bmap_word_t            fresh [4];
        bmap_word_t            want;
        slbm_pkg::coord_t      got_row;
        slbm_pkg::coord_t      got_col;
        logic                  got_edge;
        logic [DW-2*CB-2:0]    got_pad;

        if (!rst_n)
        begin
            boundary_q.delete();
            west_label       = '0;
            north_west_label = '0;
            row_at           = 0;
            col_at           = 0;
            width_cfg        = slbm_pkg::RST_FRAME_WIDTH;
            height_cfg       = slbm_pkg::RST_FRAME_HEIGHT;
            mismatches       = 0;
            words_seen       = 0;
            pending_words    = 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                if (cfg_addr == slbm_pkg::REG_FRAME_WIDTH)
                    width_cfg = cfg_wdata;
                else
                    height_cfg = cfg_wdata;
                row_at = 0;
                col_at = 0;
            end

            if (s_tvalid === 1'b1 && s_tready === 1'b1)
            begin
                w   = frame_dim(width_cfg, WIDTH_CAP);
                h   = frame_dim(height_cfg, slbm_pkg::MAX_FRAME);
                lab = s_tdata[LABEL_BITS-1:0];
                r   = (row_at >= h) ? h - 1 : row_at;
                c   = (col_at >= w) ? w - 1 : col_at;
                up  = prev_row[c];
                n   = 0;
                if (r >= 1)
                begin
                    if (c >= 1)
                    begin
                        fresh[n] = make_word(r - 1, c - 1,
                            (north_west_label != up) || (west_label != lab) ||
                            (north_west_label != west_label) || (up != lab));
                        n++;
                    end
                    if (c == w - 1)
                    begin
                        fresh[n] = make_word(r - 1, c, up != lab);
                        n++;
                    end
                end
                if (r == h - 1)
                begin
                    if (c >= 1)
                    begin
                        fresh[n] = make_word(r, c - 1, west_label != lab);
                        n++;
                    end
                    if (c == w - 1)
                    begin
                        fresh[n] = make_word(r, c, 1'b0);
                        n++;
                    end
                end
                for (k = 0; k < n; k++)
                begin
                    if (k == n - 1)
                        fresh[k].last = 1'b1;
                    boundary_q.push_back(fresh[k]);
                end

                prev_row[c]      = lab;
                north_west_label = up;
                west_label       = lab;
                if (c + 1 >= w)
                begin
                    col_at = 0;
                    row_at = (r + 1 >= h) ? 0 : r + 1;
                end
                else
                begin
                    col_at = c + 1;
                    row_at = r;
                end
            end

            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got_row  = m_tdata[CB-1:0];
                got_col  = m_tdata[2*CB-1:CB];
                got_edge = m_tdata[2*CB];
                got_pad  = m_tdata[DW-1:2*CB+1];
                if (boundary_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word row %0d col %0d edge %0d last %0d",
                             $time, got_row, got_col, got_edge, m_tlast);
                end
                else
                begin
                    want = boundary_q.pop_front();
                    words_seen++;
                    if (got_row !== want.row || got_col !== want.col ||
                        got_edge !== want.on_edge || m_tlast !== want.last ||
                        got_pad !== '0)
                    begin
                        mismatches++;
                        $display("%0t: word mismatch, expected row %0d col %0d edge %0d last %0d pad 0, got row %0d col %0d edge %0d last %0d pad %0h",
                                 $time, want.row, want.col, want.on_edge, want.last,
                                 got_row, got_col, got_edge, m_tlast, got_pad);
                    end
                end
            end

            pending_words = boundary_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives the label to boundary map core with directed frames and random
// frame shapes, random source gaps and sink stalls; the monitor checks every
// boundary word and this module reports the verdict
// ----------------------------------------------------------------------------
module tb;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic           cfg_addr  = 1'b0;
    slbm_pkg::cfg_t cfg_wdata = '0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [15:0]    s_tdata   = '0;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [slbm_pkg::OUT_DATA_BITS-1:0] m_tdata;
    logic           m_tlast;

    int          mismatches;
    int          pending_words;
    int          words_seen;
    int          labels_sent = 0;
    int          setups      = 0;
    int          sink_hold   = 0;
    bit          steady      = 1'b0;
    logic [15:0] palette [4];

    always #6 clk = ~clk;

    segment_label_to_boundary_map_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    boundary_map_monitor u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_words (pending_words),
        .words_seen    (words_seen)
    );

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] next_label();
        int p;
        p = $urandom_range(0, 19);
        if (p < 15)
            return palette[$urandom_range(0, 3)];
        if (p < 18)
            return 16'($urandom);
        return (p == 18) ? 16'h0000 : 16'hFFFF;
    endfunction

    // sink side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else if (sink_hold != 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= idle_len();
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_label(input logic [15:0] lab);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lab;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        labels_sent++;
    endtask

    // wait until every predicted word is out and stray pixels have settled
    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            while (pending_words != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
        while (pending_words != 0);
    endtask

    task automatic set_frame(input bit do_w, input bit do_h,
                             input slbm_pkg::cfg_t w, input slbm_pkg::cfg_t h);
        if (do_w)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= slbm_pkg::REG_FRAME_WIDTH;
            cfg_wdata <= w;
            @(posedge clk);
        end
        if (do_h)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= slbm_pkg::REG_FRAME_HEIGHT;
            cfg_wdata <= h;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        setups++;
    endtask

    initial
    begin : stimulus
        logic [15:0]    grid3 [9];
        logic [15:0]    tall2 [6];
        int             pick;
        int             n;
        int             k;
        slbm_pkg::cfg_t w;
        slbm_pkg::cfg_t h;

        grid3 = '{16'h0000, 16'h0000, 16'hFFFF,
                  16'h0000, 16'h0000, 16'hFFFF,
                  16'h1234, 16'h1234, 16'h1234};
        tall2 = '{16'h0001, 16'h0001, 16'h0001,
                  16'h0002, 16'hFFFF, 16'hFFFF};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shape, first row only
        for (k = 0; k < 3; k++)
            send_label(16'($urandom));
        drain();

        // 3x3 frame: interior, last column, last row and corner
        set_frame(1'b1, 1'b1, 13'd3, 13'd3);
        foreach (grid3[i])
            send_label(grid3[i]);
        drain();

        // single pixel frames
        set_frame(1'b1, 1'b1, 13'd1, 13'd1);
        send_label(16'h0000);
        send_label(16'hFFFF);
        drain();
        set_frame(1'b1, 1'b1, 13'd0, 13'd0);
        send_label(16'hA5A5);
        drain();

        // oversized width on a one-row frame
        set_frame(1'b1, 1'b1, 13'h1FFF, 13'd1);
        send_label(16'hFFFF);
        send_label(16'hFFFF);
        send_label(16'h0000);
        send_label(16'h5A5A);
        drain();

        // narrow frame with oversized height, left mid-frame
        set_frame(1'b1, 1'b1, 13'd2, 13'h1FFF);
        foreach (tall2[i])
            send_label(tall2[i]);
        drain();

        while (labels_sent < 190)
        begin
            steady = ($urandom_range(0, 3) == 0);
            foreach (palette[i])
                palette[i] = 16'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                w = slbm_pkg::cfg_t'($urandom_range(4096, 8191));
                h = slbm_pkg::cfg_t'($urandom_range(0, 1));
                n = $urandom_range(8, 30);
                set_frame(1'b1, 1'b1, w, h);
            end
            else if (pick == 1)
            begin
                w = slbm_pkg::cfg_t'($urandom_range(0, 8191));
                h = slbm_pkg::cfg_t'($urandom_range(0, 8191));
                n = $urandom_range(4, 16);
                k = $urandom_range(0, 2);
                set_frame(k != 1, k != 0, w, h);
            end
            else
            begin
                w = slbm_pkg::cfg_t'($urandom_range(1, 6));
                h = slbm_pkg::cfg_t'($urandom_range(1, 6));
                n = int'(w) * int'(h) * $urandom_range(1, 3);
                if ($urandom_range(0, 2) == 0)
                    n += $urandom_range(1, int'(w) * int'(h));
                set_frame(1'b1, 1'b1, w, h);
            end
            for (k = 0; k < n; k++)
                send_label(next_label());
            drain();
        end

        steady = 1'b0;
        drain();
        $display("run covered %0d labels over %0d frame setups, sizes 0 to 8191 written",
                 labels_sent, setups);
        $display("%0d boundary words compared, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0 && pending_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
